// File: hdl/dbsr_pkg.sv
// Shared types and constants for the display bus sniffer/responder.
package dbsr_pkg;

	localparam int PAYLOAD_BYTES = 11;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// line events
	localparam logic [1:0] OP_SEL_FALL = 2'd0;
	localparam logic [1:0] OP_SEL_RISE = 2'd1;
	localparam logic [1:0] OP_CLK_RISE = 2'd2;
	localparam logic [1:0] OP_CLK_FALL = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_WRITE = 2'd1;
	localparam logic [1:0] CFG_READ = 2'd2;

	// command matcher stages
	localparam logic [1:0] STG_IDLE = 2'd0;
	localparam logic [1:0] STG_MODE = 2'd1;
	localparam logic [1:0] STG_WRITE = 2'd2;
	localparam logic [1:0] STG_BRIGHT = 2'd3;

	localparam logic [2:0] BIT_LAST = 3'd7;
	localparam logic [3:0] SEND_START = 4'd8;
	localparam logic [3:0] SEND_WRAP = 4'd15;

	localparam logic [7:0] MODE_RESET = 8'd2;
	localparam logic [7:0] WRITE_RESET = 8'd64;
	localparam logic [7:0] READ_RESET = 8'd66;
	localparam logic [2:0] BRIGHT_RESET = 3'd7;

	typedef struct packed {
		logic [1:0]  op;
		logic        data_in;
		logic [15:0] button_code;
	} in_item_t;

	typedef struct packed {
		logic       data_out;
		logic       drive_enable;
		logic       packet_valid;
		logic [3:0] byte_index;
		logic [7:0] payload_byte;
		logic [2:0] brightness;
		logic       frame_error;
		logic       last;
	} out_item_t;

	// one classified event handed from front to back
	typedef struct packed {
		logic       data_out;
		logic       drive_enable;
		logic [2:0] brightness;
		logic       frame_error;
		logic       report;
	} job_t;

	// back-to-front status
	typedef struct packed {
		logic              report_done;
		logic [ADDR_W-1:0] rd_addr;
	} back_stat_t;

endpackage

// File: hdl/dbsr_front.sv
// Front end: bus event decoder, command matcher, payload store and config registers.
module dbsr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  dbsr_pkg::in_item_t   in_item,
	input  logic                 cfg_accept,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_value,
	input  dbsr_pkg::back_stat_t back_stat,
	output logic                 report_busy,
	output dbsr_pkg::job_t       job,
	output logic [7:0]           rd_byte
);
	import dbsr_pkg::*;

	logic [7:0] mode_cmd_q, write_cmd_q, read_cmd_q;
	logic sel_q, drv_q, err_q, held_q, busy_q;
	logic [7:0] shift_q;
	logic [2:0] bitcnt_q;
	logic [CNT_W-1:0] bytecnt_q;
	logic [1:0] stage_q;
	logic [3:0] send_q;
	logic [2:0] bright_q;
	logic [7:0] store_q [PAYLOAD_BYTES];

	logic sel_n, drv_n, err_n, held_n, report;
	logic [7:0] shift_n;
	logic [2:0] bitcnt_n;
	logic [CNT_W-1:0] bytecnt_n;
	logic [1:0] stage_n;
	logic [3:0] send_n;
	logic [2:0] bright_n;
	logic wr_en;

	always_comb begin
		sel_n = sel_q;
		drv_n = drv_q;
		err_n = err_q;
		held_n = held_q;
		shift_n = shift_q;
		bitcnt_n = bitcnt_q;
		bytecnt_n = bytecnt_q;
		stage_n = stage_q;
		send_n = send_q;
		bright_n = bright_q;
		report = 1'b0;
		wr_en = 1'b0;
		case (in_item.op)
			OP_SEL_FALL: begin
				sel_n = 1'b1;
			end
			OP_SEL_RISE: begin
				sel_n = 1'b0;
				drv_n = 1'b0;
				if ((bytecnt_q != CNT_W'(PAYLOAD_BYTES) && bytecnt_q != '0) || bitcnt_q != '0)
					err_n = 1'b1;
				bytecnt_n = '0;
				bitcnt_n = '0;
				if (shift_q == mode_cmd_q) begin
					stage_n = STG_MODE;
				end else if (shift_q == write_cmd_q) begin
					stage_n = (stage_q == STG_MODE) ? STG_WRITE : STG_IDLE;
				end else if (stage_q == STG_BRIGHT) begin
					bright_n = shift_q[2:0];
					stage_n = STG_IDLE;
					report = 1'b1;
				end else if (stage_q == STG_WRITE) begin
					stage_n = STG_BRIGHT;
				end
			end
			OP_CLK_RISE: begin
				if (sel_q && !drv_q) begin
					shift_n = {in_item.data_in, shift_q[7:1]};
					if (bitcnt_q == BIT_LAST) begin
						bitcnt_n = '0;
						if (stage_q == STG_WRITE) begin
							if (bytecnt_q < CNT_W'(PAYLOAD_BYTES)) begin
								wr_en = 1'b1;
								bytecnt_n = bytecnt_q + 1'b1;
							end else begin
								err_n = 1'b1;
							end
						end else if (shift_n == read_cmd_q) begin
							send_n = SEND_START;
							drv_n = 1'b1;
						end
					end else begin
						bitcnt_n = bitcnt_q + 1'b1;
					end
				end
			end
			OP_CLK_FALL: begin
				if (sel_q && drv_q) begin
					held_n = in_item.button_code[send_q];
					send_n = (send_q >= SEND_WRAP) ? 4'd0 : send_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign job = '{data_out: held_n, drive_enable: drv_n, brightness: bright_n,
		frame_error: err_n, report: report};
	assign report_busy = busy_q;
	assign rd_byte = store_q[back_stat.rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cmd_q <= MODE_RESET;
			write_cmd_q <= WRITE_RESET;
			read_cmd_q <= READ_RESET;
		end else if (cfg_accept) begin
			case (cfg_index)
				CFG_MODE:  mode_cmd_q <= cfg_value;
				CFG_WRITE: write_cmd_q <= cfg_value;
				CFG_READ:  read_cmd_q <= cfg_value;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			drv_q <= 1'b0;
			err_q <= 1'b0;
			held_q <= 1'b0;
			shift_q <= '0;
			bitcnt_q <= '0;
			bytecnt_q <= '0;
			stage_q <= STG_IDLE;
			send_q <= SEND_START;
			bright_q <= BRIGHT_RESET;
			busy_q <= 1'b0;
		end else begin
			if (in_accept) begin
				sel_q <= sel_n;
				drv_q <= drv_n;
				err_q <= report ? 1'b0 : err_n; // sticky flag clears once reported
				held_q <= held_n;
				shift_q <= shift_n;
				bitcnt_q <= bitcnt_n;
				bytecnt_q <= bytecnt_n;
				stage_q <= stage_n;
				send_q <= send_n;
				bright_q <= bright_n;
			end
			// hold off new events until the back end has read out the whole store
			if (in_accept && report)
				busy_q <= 1'b1;
			else if (back_stat.report_done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && wr_en)
			store_q[bytecnt_q[ADDR_W-1:0]] <= shift_n;
	end

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_accept) else $error("event accepted during frame report");
	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.report_done |-> busy_q) else $error("report done without pending report");

endmodule

// File: hdl/dbsr_queue.sv
// Short job queue between the front and back ends.
module dbsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dbsr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output dbsr_pkg::job_t head
);
	import dbsr_pkg::*;

	job_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = slot_q[rd_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

// File: hdl/dbsr_back.sv
// Back end: expands jobs into result beats, frame reports into one beat per payload byte.
module dbsr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  dbsr_pkg::job_t       q_head,
	output logic                 q_pop,
	input  logic [7:0]           rd_byte,
	output dbsr_pkg::back_stat_t back_stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dbsr_pkg::out_item_t  out_data
);
	import dbsr_pkg::*;

	logic out_valid_q, rpt_q;
	out_item_t out_q;
	job_t cur_q;
	logic [ADDR_W-1:0] idx_q;
	logic load, idx_last;
	logic [ADDR_W-1:0] idx_now;

	assign load = !out_valid_q || out_ready;
	assign q_pop = load && !rpt_q && q_not_empty;
	assign idx_now = rpt_q ? idx_q : '0;
	assign idx_last = (idx_now == ADDR_W'(PAYLOAD_BYTES - 1));
	assign back_stat.rd_addr = idx_now;
	assign back_stat.report_done = load && idx_last &&
		(rpt_q || (q_pop && q_head.report));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rpt_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			if (rpt_q) begin
				out_valid_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
				if (idx_last)
					rpt_q <= 1'b0;
			end else if (q_not_empty) begin
				out_valid_q <= 1'b1;
				if (q_head.report && !idx_last) begin
					rpt_q <= 1'b1;
					idx_q <= ADDR_W'(1);
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (rpt_q) begin
				out_q <= '{data_out: cur_q.data_out, drive_enable: cur_q.drive_enable,
					packet_valid: 1'b1, byte_index: 4'(idx_now), payload_byte: rd_byte,
					brightness: cur_q.brightness, frame_error: cur_q.frame_error,
					last: idx_last};
			end else if (q_not_empty) begin
				cur_q <= q_head;
				out_q <= '{data_out: q_head.data_out, drive_enable: q_head.drive_enable,
					packet_valid: q_head.report, byte_index: 4'd0,
					payload_byte: q_head.report ? rd_byte : 8'd0,
					brightness: q_head.brightness, frame_error: q_head.frame_error,
					last: !q_head.report || idx_last};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_q |-> idx_q < ADDR_W'(PAYLOAD_BYTES)) else $error("report index out of range");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.report_done |=> out_valid_q && out_q.last && out_q.packet_valid)
		else $error("report done without final report beat");
	a_no_pop_rpt: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_q |-> !q_pop) else $error("queue popped during report");

endmodule

// File: hdl/display_bus_sniffer_responder_unit.sv
// Queue holds two jobs; an event is registered there, then in the output register.
// Throughput: one event per cycle while results drain and no report is pending; a
// frame report gives PAYLOAD_BYTES (11) result beats, one per cycle while they drain,
// through the back end's index counter; new events wait until its last beat is loaded.
// Reset (arst_n low, asynchronous): matcher, counters, flags and config registers
// return to their initial values; the payload store is not cleared.
module display_bus_sniffer_responder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dbsr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dbsr_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_value
);
	import dbsr_pkg::*;

	logic q_full, q_not_empty, q_pop, report_busy, in_accept;
	job_t job, q_head;
	back_stat_t back_stat;
	logic [7:0] rd_byte;

	assign in_ready = !q_full && !report_busy;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	dbsr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(in_accept),
		.in_item(in_data),
		.cfg_accept(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_value(cfg_value),
		.back_stat(back_stat),
		.report_busy(report_busy),
		.job(job),
		.rd_byte(rd_byte)
	);

	dbsr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_accept),
		.push_job(job),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	dbsr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.rd_byte(rd_byte),
		.back_stat(back_stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
